[rtl/mse_pkg.sv]
`default_nettype none

package mse_pkg;

   // Default for the top level's MAX_ELEMENTS parameter.
   localparam int MaxElementsDefault = 4096;

   localparam int DataW     = 16;
   localparam int DiffW     = 17;
   localparam int LenCfgW   = 13;
   localparam int ScaleW    = 18;
   localparam int RecipW    = 25;
   localparam int SumW      = 48;
   localparam int SquareW   = 32;
   localparam int GradW     = 18;
   localparam int LossW     = 32;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 25;

   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = 1;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_ELEMENTS   = 2'd0,
      CSR_GRAD_SCALE = 2'd1,
      CSR_MEAN_RECIP = 2'd2
   } csr_index_type;

   // One classified word handed from the front to the back.
   typedef struct packed {
      logic signed [DiffW-1:0] diff;
      logic                    last;
   } work_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_ACC,
      BACK_MEAN,
      BACK_DONE
   } back_state_type;

endpackage

`default_nettype wire

[rtl/mse_front.sv]
`default_nettype none

module mse_front #(
   parameter int MAX_ELEMENTS = mse_pkg::MaxElementsDefault
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   input  wire                                  queue_full,
   input  wire signed [mse_pkg::DataW-1:0]      req_prediction,
   input  wire signed [mse_pkg::DataW-1:0]      req_target_value,
   input  wire        [mse_pkg::LenCfgW-1:0]    elements_per_sample,
   output logic                                 push,
   output mse_pkg::work_type                    push_word
);

   localparam int LenW = ($clog2(MAX_ELEMENTS + 1) > mse_pkg::LenCfgW) ?
                         $clog2(MAX_ELEMENTS + 1) : mse_pkg::LenCfgW;
   localparam int CntW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic [LenW-1:0] cfg_len;
   logic [LenW-1:0] eff_len;
   logic [LenW-1:0] count_next;
   logic            closes;

   always_comb begin
      cfg_len = LenW'(elements_per_sample);
      if (cfg_len == '0) begin
         eff_len = LenW'(1);
      end else if (cfg_len > LenW'(MAX_ELEMENTS)) begin
         eff_len = LenW'(MAX_ELEMENTS);
      end else begin
         eff_len = cfg_len;
      end
      count_next = LenW'(count_ff) + LenW'(1);
      // A count that already reaches a lowered length closes the sample too.
      closes = (count_next >= eff_len);
   end

   assign push = req_valid && !queue_full;

   always_comb begin
      push_word.diff = mse_pkg::DiffW'(req_prediction) - mse_pkg::DiffW'(req_target_value);
      push_word.last = closes;
   end

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = closes ? '0 : CntW'(count_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/mse_queue.sv]
`default_nettype none

module mse_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  wire mse_pkg::work_type push_word,
   input  wire                    pop,
   output logic                   full,
   output logic                   empty,
   output mse_pkg::work_type      head
);

   localparam int CountW = mse_pkg::QueuePtrW + 1;

   mse_pkg::work_type                  entry_ff [mse_pkg::QueueDepth];
   logic [mse_pkg::QueuePtrW-1:0]      wr_ptr_ff;
   logic [mse_pkg::QueuePtrW-1:0]      wr_ptr_in;
   logic [mse_pkg::QueuePtrW-1:0]      rd_ptr_ff;
   logic [mse_pkg::QueuePtrW-1:0]      rd_ptr_in;
   logic [CountW-1:0]                  fill_ff;
   logic [CountW-1:0]                  fill_in;

   assign full  = (fill_ff == CountW'(mse_pkg::QueueDepth));
   assign empty = (fill_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + CountW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

[rtl/mse_back.sv]
`default_nettype none

module mse_back (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  queue_empty,
   input  wire mse_pkg::work_type               head,
   output logic                                 pop,
   input  wire        [mse_pkg::ScaleW-1:0]     gradient_scale,
   input  wire        [mse_pkg::RecipW-1:0]     mean_reciprocal,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [mse_pkg::GradW-1:0]     rsp_gradient,
   output logic       [mse_pkg::LossW-1:0]      rsp_sample_loss,
   output logic                                 rsp_loss_valid
);

   localparam int ProdW  = mse_pkg::DiffW + mse_pkg::ScaleW + 1;
   localparam int SqFullW = 2 * mse_pkg::DiffW;
   localparam int HalfW  = mse_pkg::SumW / 2;
   localparam int MeanPW = HalfW + mse_pkg::RecipW;
   localparam int MeanW  = MeanPW + 1;

   mse_pkg::back_state_type state_ff;
   mse_pkg::back_state_type state_in;
   logic                    out_load;

   logic signed [ProdW-1:0]            grad_prod_ff;
   logic signed [ProdW-1:0]            grad_prod_in;
   logic signed [SqFullW-1:0]          square_full;
   logic [mse_pkg::SquareW-1:0]        square_ff;
   logic                               last_ff;
   logic signed [mse_pkg::GradW-1:0]   grad_ff;
   logic signed [mse_pkg::GradW-1:0]   grad_in;
   logic signed [ProdW-17:0]           grad_floor;
   logic [mse_pkg::SumW-1:0]           sum_ff;
   logic [mse_pkg::SumW-1:0]           sum_in;
   logic [mse_pkg::SumW:0]             sum_wide;
   logic [mse_pkg::SumW-1:0]           sum_sat;
   logic [mse_pkg::SumW-1:0]           total_ff;
   logic [MeanPW-1:0]                  hi_prod_ff;
   logic [MeanPW-1:0]                  lo_prod_ff;
   logic [MeanW-1:0]                   mean_wide;
   logic [mse_pkg::LossW-1:0]          mean_sat;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic signed [mse_pkg::GradW-1:0]   rsp_gradient_ff;
   logic [mse_pkg::LossW-1:0]          rsp_sample_loss_ff;
   logic                               rsp_loss_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mse_pkg::BACK_IDLE: begin
            if (!queue_empty) begin
               state_in = mse_pkg::BACK_ACC;
            end
         end
         mse_pkg::BACK_ACC:  state_in = mse_pkg::BACK_MEAN;
         mse_pkg::BACK_MEAN: state_in = mse_pkg::BACK_DONE;
         mse_pkg::BACK_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = mse_pkg::BACK_IDLE;
            end
         end
         default: state_in = mse_pkg::BACK_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      pop      = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         mse_pkg::BACK_IDLE: pop = !queue_empty;
         mse_pkg::BACK_DONE: out_load = !rsp_valid_ff || !rsp_stall;
         default: begin
            pop      = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   // Datapath arithmetic.
   always_comb begin
      grad_prod_in = head.diff * $signed({1'b0, gradient_scale});
      square_full  = head.diff * head.diff;

      // Arithmetic shift floors toward minus infinity, then clamp to 18 bits.
      grad_floor = grad_prod_ff[ProdW-1:16];
      if (grad_floor > $signed((ProdW-16)'(2 ** (mse_pkg::GradW - 1) - 1))) begin
         grad_in = {1'b0, {(mse_pkg::GradW-1){1'b1}}};
      end else if (grad_floor < -$signed((ProdW-16)'(2 ** (mse_pkg::GradW - 1)))) begin
         grad_in = {1'b1, {(mse_pkg::GradW-1){1'b0}}};
      end else begin
         grad_in = grad_floor[mse_pkg::GradW-1:0];
      end

      sum_wide = {1'b0, sum_ff} + (mse_pkg::SumW+1)'(square_ff);
      sum_sat  = sum_wide[mse_pkg::SumW] ? '1 : sum_wide[mse_pkg::SumW-1:0];

      sum_in = sum_ff;
      if (state_ff == mse_pkg::BACK_ACC) begin
         sum_in = last_ff ? '0 : sum_sat;
      end

      mean_wide = {1'b0, hi_prod_ff} + MeanW'(lo_prod_ff[MeanPW-1:HalfW]);
      mean_sat  = (mean_wide[MeanW-1:mse_pkg::LossW] != '0) ? '1 :
                  mean_wide[mse_pkg::LossW-1:0];

      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         grad_prod_ff <= grad_prod_in;
         square_ff    <= square_full[mse_pkg::SquareW-1:0];
         last_ff      <= head.last;
      end
      if (state_ff == mse_pkg::BACK_ACC) begin
         grad_ff  <= grad_in;
         total_ff <= sum_sat;
      end
      if (state_ff == mse_pkg::BACK_MEAN) begin
         hi_prod_ff <= total_ff[mse_pkg::SumW-1:HalfW] * mean_reciprocal;
         lo_prod_ff <= total_ff[HalfW-1:0] * mean_reciprocal;
      end
      if (out_load) begin
         rsp_gradient_ff    <= grad_ff;
         rsp_sample_loss_ff <= last_ff ? mean_sat : '0;
         rsp_loss_valid_ff  <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mse_pkg::BACK_IDLE;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gradient    = rsp_gradient_ff;
   assign rsp_sample_loss = rsp_sample_loss_ff;
   assign rsp_loss_valid  = rsp_loss_valid_ff;

endmodule

`default_nettype wire

[rtl/mse_loss_and_gradient.sv]
// Channel   Direction  Handshake          Word
// req       in         req_valid/stall    prediction, target_value (signed Q4.12)
// rsp       out        rsp_valid/stall    gradient, sample_loss, loss_valid
// csr       in         csr_write          csr_index selects register, csr_data
//
// Each word passes in order through products, accumulate, mean multiplies and
// output load in the back-end sequencer, which pops the next word only afterwards.
// The front classifies words into a two-entry queue and keeps taking them while a
// result waits on a stalled rsp channel until the queue fills. Synchronous reset
// clears the accumulator, element counter and queue and restores register defaults.
`default_nettype none

module mse_loss_and_gradient #(
   parameter int MAX_ELEMENTS = mse_pkg::MaxElementsDefault
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire signed [mse_pkg::DataW-1:0]      req_prediction,
   input  wire signed [mse_pkg::DataW-1:0]      req_target_value,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [mse_pkg::GradW-1:0]     rsp_gradient,
   output logic       [mse_pkg::LossW-1:0]      rsp_sample_loss,
   output logic                                 rsp_loss_valid,
   input  wire                                  csr_write,
   input  wire        [mse_pkg::CsrIndexW-1:0]  csr_index,
   input  wire        [mse_pkg::CsrDataW-1:0]   csr_data
);

   logic [mse_pkg::LenCfgW-1:0] elements_ff;
   logic [mse_pkg::ScaleW-1:0]  scale_ff;
   logic [mse_pkg::RecipW-1:0]  recip_ff;

   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_empty;
   mse_pkg::work_type push_word;
   mse_pkg::work_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         elements_ff <= mse_pkg::LenCfgW'(1);
         scale_ff    <= mse_pkg::ScaleW'(131072);
         recip_ff    <= mse_pkg::RecipW'(16777216);
      end else if (csr_write) begin
         if (csr_index == mse_pkg::CSR_ELEMENTS) begin
            elements_ff <= csr_data[mse_pkg::LenCfgW-1:0];
         end else if (csr_index == mse_pkg::CSR_GRAD_SCALE) begin
            scale_ff <= csr_data[mse_pkg::ScaleW-1:0];
         end else if (csr_index == mse_pkg::CSR_MEAN_RECIP) begin
            recip_ff <= csr_data[mse_pkg::RecipW-1:0];
         end
      end
   end

   assign req_stall = queue_full;

   mse_front #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .queue_full          (queue_full),
      .req_prediction      (req_prediction),
      .req_target_value    (req_target_value),
      .elements_per_sample (elements_ff),
      .push                (push),
      .push_word           (push_word)
   );

   mse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (head)
   );

   mse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .head            (head),
      .pop             (pop),
      .gradient_scale  (scale_ff),
      .mean_reciprocal (recip_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_gradient    (rsp_gradient),
      .rsp_sample_loss (rsp_sample_loss),
      .rsp_loss_valid  (rsp_loss_valid)
   );

endmodule

`default_nettype wire
